// File: rtl/core/hdu_pkg.sv
// shared constants and elaboration-time table functions for the haversine distance unit
package hdu_pkg;

  localparam int CONST_BITS = 60;

  localparam logic signed [30:0] LAT_LIMIT   = 31'sd900000000;
  localparam logic signed [31:0] LON_LIMIT   = 32'sd1800000000;
  localparam logic signed [32:0] LON_LIMIT_W = 33'sd1800000000;
  localparam logic signed [32:0] LON_SPAN    = 33'sd3600000000;
  localparam logic signed [31:0] DIAMETER_CM = 32'sd1275627400;
  localparam logic signed [32:0] MAX_DIST    = 33'sd2003750840;

  // sign-magnitude product, magnitude truncated after the shift
  function automatic longint mulsh(input longint a, input longint b, input int sh);
    logic         neg;
    logic [63:0]  ua;
    logic [63:0]  ub;
    logic [127:0] p;
    logic [63:0]  r;
    neg = (a < 0) != (b < 0);
    ua  = (a < 0) ? 64'(-a) : 64'(a);
    ub  = (b < 0) ? 64'(-b) : 64'(b);
    p   = {64'd0, ua} * {64'd0, ub};
    r   = 64'(p >> sh);
    r[63] = 1'b0;
    return neg ? -longint'(r) : longint'(r);
  endfunction

  // unsigned shift-and-subtract quotient
  function automatic longint unsigned div_u64(input longint unsigned n,
                                              input longint unsigned d);
    longint unsigned q;
    longint unsigned r;
    q = 64'd0;
    r = 64'd0;
    for (int i = 63; i >= 0; i--) begin
      r = {r[62:0], n[i]};
      if (r >= d) begin
        r    = r - d;
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  // pi in q60 by machin series
  function automatic longint pi_q60();
    longint p5;
    longint p239;
    longint s5;
    longint s239;
    longint t;
    p5   = (longint'(1) <<< CONST_BITS) / 5;
    p239 = (longint'(1) <<< CONST_BITS) / 239;
    s5   = 0;
    s239 = 0;
    for (int k = 0; k < 40; k++) begin
      if (p5 != 0) begin
        t  = longint'(div_u64(64'(p5), 64'(2 * k + 1)));
        s5 = (k % 2 == 1) ? s5 - t : s5 + t;
        p5 = longint'(div_u64(64'(p5), 64'd25));
      end
      if (p239 != 0) begin
        t    = longint'(div_u64(64'(p239), 64'(2 * k + 1)));
        s239 = (k % 2 == 1) ? s239 - t : s239 + t;
        p239 = longint'(div_u64(64'(p239), 64'd57121));
      end
    end
    return 16 * s5 - 4 * s239;
  endfunction

  // atan(2^-m) in q60
  function automatic longint atan_pow2(input int m);
    longint unsigned p;
    longint          sum;
    longint          t;
    int              sh;
    p   = 64'd1 << (CONST_BITS - m);
    sum = 0;
    sh  = 2 * m;
    for (int k = 0; k < 64; k++) begin
      if (p != 0) begin
        t   = longint'(div_u64(p, 64'(2 * k + 1)));
        sum = (k % 2 == 1) ? sum - t : sum + t;
        p   = (sh < 64) ? (p >> sh) : 64'd0;
      end
    end
    return sum;
  endfunction

  function automatic longint to_frac(input longint v, input int f);
    int d;
    d = CONST_BITS - f;
    return (v + (longint'(1) <<< (d - 1))) >>> d;
  endfunction

  function automatic longint atan_frac(input int i, input int f);
    return to_frac((i == 0) ? pi_q60() / 4 : atan_pow2(i), f);
  endfunction

  // reciprocal of the cordic gain by newton iteration on 1/sqrt
  function automatic longint gain_frac(input int stages, input int f);
    longint g2;
    longint k;
    longint t;
    g2 = longint'(1) <<< CONST_BITS;
    for (int i = 0; i < stages; i++) begin
      if (2 * i < 64) g2 = g2 + (g2 >>> (2 * i));
    end
    k = ((longint'(1) <<< CONST_BITS) / 10) * 6;
    for (int i = 0; i < 8; i++) begin
      t = mulsh(g2, mulsh(k, k, CONST_BITS), CONST_BITS);
      k = mulsh(k, 3 * (longint'(1) <<< CONST_BITS) - t, CONST_BITS + 1);
    end
    return to_frac(k, f);
  endfunction

  // pi / 1.8e9 in q92
  function automatic logic [63:0] unit_scale_q92();
    logic [63:0] pi;
    logic [63:0] q;
    logic [63:0] r;
    pi = 64'(pi_q60());
    q  = div_u64(pi, 64'd1800000000);
    r  = pi - q * 64'd1800000000;
    return (q << 32) + div_u64(r << 32, 64'd1800000000);
  endfunction

  localparam logic signed [63:0] UNIT_SCALE = unit_scale_q92();

endpackage

// File: rtl/core/haversine_distance_unit.sv
// top level of the haversine great-circle distance unit
// Takes two positions in 1e-7 degree and returns their great-circle distance in
// centimeters on a sphere of 6378137 m. It accepts one transaction per clock while
// in_stall is low and returns results in order; the pipeline runs through the
// two chains of cordic cells, the bit-per-cell square root and the split
// multipliers. A full output register with a one-entry skid buffer raises in_stall
// only while both hold results the receiver has not yet taken.
module haversine_distance_unit #(
  parameter int FRACTION_BITS = 32,
  parameter int CORDIC_STAGES = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [30:0] in_first_latitude,
  input  logic signed [31:0] in_first_longitude,
  input  logic signed [30:0] in_second_latitude,
  input  logic signed [31:0] in_second_longitude,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [30:0]        out_distance_cm
);

  localparam int F   = FRACTION_BITS;
  localparam int N   = CORDIC_STAGES;
  localparam int WD  = F + 3;
  localparam int WR  = 2 * F + 2;
  localparam int LAT = 2 * N + F + 15;

  localparam logic signed [WD-1:0] GAIN  = WD'(hdu_pkg::gain_frac(N, F));
  localparam logic [F:0]           ONE_U = {1'b1, {F{1'b0}}};
  localparam logic signed [WD-1:0] ONE_S = {2'b00, ONE_U};

  logic en;
  logic [LAT-1:0] vld_r, vld_nxt;

  // input clamp
  logic signed [30:0] lat1_r, lat1_nxt, lat2_r, lat2_nxt;
  logic signed [31:0] lon1_r, lon1_nxt, lon2_r, lon2_nxt;

  always_comb begin
    lat1_nxt = (in_first_latitude > hdu_pkg::LAT_LIMIT) ? hdu_pkg::LAT_LIMIT :
               (in_first_latitude < -hdu_pkg::LAT_LIMIT) ? -hdu_pkg::LAT_LIMIT :
               in_first_latitude;
    lat2_nxt = (in_second_latitude > hdu_pkg::LAT_LIMIT) ? hdu_pkg::LAT_LIMIT :
               (in_second_latitude < -hdu_pkg::LAT_LIMIT) ? -hdu_pkg::LAT_LIMIT :
               in_second_latitude;
    lon1_nxt = (in_first_longitude > hdu_pkg::LON_LIMIT) ? hdu_pkg::LON_LIMIT :
               (in_first_longitude < -hdu_pkg::LON_LIMIT) ? -hdu_pkg::LON_LIMIT :
               in_first_longitude;
    lon2_nxt = (in_second_longitude > hdu_pkg::LON_LIMIT) ? hdu_pkg::LON_LIMIT :
               (in_second_longitude < -hdu_pkg::LON_LIMIT) ? -hdu_pkg::LON_LIMIT :
               in_second_longitude;
  end

  // differences
  logic signed [31:0] dlat_r, dlat_nxt, la1_d_r, la2_d_r;
  logic signed [32:0] dlon_r, dlon_nxt;

  assign dlat_nxt = 32'(lat2_r) - 32'(lat1_r);
  assign dlon_nxt = 33'(lon2_r) - 33'(lon1_r);

  // longitude wrap
  logic signed [31:0] dlat_w_r, dlon_w_r, dlon_w_nxt, la1_w_r, la2_w_r;

  always_comb begin
    if (dlon_r > hdu_pkg::LON_LIMIT_W) begin
      dlon_w_nxt = 32'(dlon_r - hdu_pkg::LON_SPAN);
    end else if (dlon_r < -hdu_pkg::LON_LIMIT_W) begin
      dlon_w_nxt = 32'(dlon_r + hdu_pkg::LON_SPAN);
    end else begin
      dlon_w_nxt = 32'(dlon_r);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lat1_r   <= lat1_nxt;
      lat2_r   <= lat2_nxt;
      lon1_r   <= lon1_nxt;
      lon2_r   <= lon2_nxt;
      dlat_r   <= dlat_nxt;
      dlon_r   <= dlon_nxt;
      la1_d_r  <= 32'(lat1_r);
      la2_d_r  <= 32'(lat2_r);
      dlat_w_r <= dlat_r;
      dlon_w_r <= dlon_w_nxt;
      la1_w_r  <= la1_d_r;
      la2_w_r  <= la2_d_r;
    end
  end

  // scaling to radians and sine/cosine chains
  logic signed [31:0]   lane_v [4];
  logic signed [WD-1:0] rx [4][N+1];
  logic signed [WD-1:0] ry [4][N+1];
  logic signed [WD-1:0] rz [4][N+1];

  assign lane_v[0] = dlat_w_r;
  assign lane_v[1] = dlon_w_r;
  assign lane_v[2] = la1_w_r;
  assign lane_v[3] = la2_w_r;

  for (genvar l = 0; l < 4; l++) begin : g_lane
    localparam int SHIFT = (l < 2) ? 93 - F : 92 - F;

    hdu_mul #(.WA(32), .WB(64), .WO(WD), .SH(SHIFT)) u_scale (
      .clk (clk),
      .en  (en),
      .a   (lane_v[l]),
      .b   (hdu_pkg::UNIT_SCALE),
      .p   (rz[l][0])
    );

    assign rx[l][0] = GAIN;
    assign ry[l][0] = '0;

    for (genvar k = 0; k < N; k++) begin : g_rot
      hdu_rot_cell #(.FRACTION_BITS(F), .I(k), .WD(WD)) u_cell (
        .clk   (clk),
        .en    (en),
        .x_in  (rx[l][k]),
        .y_in  (ry[l][k]),
        .z_in  (rz[l][k]),
        .x_out (rx[l][k+1]),
        .y_out (ry[l][k+1]),
        .z_out (rz[l][k+1])
      );
    end
  end

  // haversine term
  logic signed [WD-1:0] sl2, sn2, cc, hv;
  logic signed [WD-1:0] sl2_d1_r, sl2_d2_r;
  logic signed [WD-1:0] a_sum_r, a_sum_nxt;
  logic [F:0]           a_v_r, a_v_nxt, a_w_r, a_w_nxt;

  hdu_mul #(.WA(WD), .WB(WD), .WO(WD), .SH(F)) u_mul_sl (
    .clk (clk), .en (en), .a (ry[0][N]), .b (ry[0][N]), .p (sl2)
  );

  hdu_mul #(.WA(WD), .WB(WD), .WO(WD), .SH(F)) u_mul_sn (
    .clk (clk), .en (en), .a (ry[1][N]), .b (ry[1][N]), .p (sn2)
  );

  hdu_mul #(.WA(WD), .WB(WD), .WO(WD), .SH(F)) u_mul_cc (
    .clk (clk), .en (en), .a (rx[2][N]), .b (rx[3][N]), .p (cc)
  );

  hdu_mul #(.WA(WD), .WB(WD), .WO(WD), .SH(F)) u_mul_hv (
    .clk (clk), .en (en), .a (cc), .b (sn2), .p (hv)
  );

  assign a_sum_nxt = sl2_d2_r + hv;

  always_comb begin
    if (a_sum_r[WD-1]) begin
      a_v_nxt = '0;
      a_w_nxt = ONE_U;
    end else if (a_sum_r > ONE_S) begin
      a_v_nxt = ONE_U;
      a_w_nxt = '0;
    end else begin
      a_v_nxt = a_sum_r[F:0];
      a_w_nxt = ONE_U - a_sum_r[F:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sl2_d1_r <= sl2;
      sl2_d2_r <= sl2_d1_r;
      a_sum_r  <= a_sum_nxt;
      a_v_r    <= a_v_nxt;
      a_w_r    <= a_w_nxt;
    end
  end

  // square roots of a and 1 - a
  logic [WR-1:0] qa_rem [F+2];
  logic [F:0]    qa_root [F+2];
  logic [WR-1:0] qb_rem [F+2];
  logic [F:0]    qb_root [F+2];

  assign qa_rem[0]  = WR'({a_v_r, {F{1'b1}}});
  assign qa_root[0] = '0;
  assign qb_rem[0]  = WR'({a_w_r, {F{1'b1}}});
  assign qb_root[0] = '0;

  for (genvar k = 0; k <= F; k++) begin : g_sqrt
    hdu_sqrt_cell #(.FRACTION_BITS(F), .B(F - k)) u_cell_a (
      .clk      (clk),
      .en       (en),
      .rem_in   (qa_rem[k]),
      .root_in  (qa_root[k]),
      .rem_out  (qa_rem[k+1]),
      .root_out (qa_root[k+1])
    );

    hdu_sqrt_cell #(.FRACTION_BITS(F), .B(F - k)) u_cell_b (
      .clk      (clk),
      .en       (en),
      .rem_in   (qb_rem[k]),
      .root_in  (qb_root[k]),
      .rem_out  (qb_rem[k+1]),
      .root_out (qb_root[k+1])
    );
  end

  // central angle
  logic signed [WD-1:0] vx [N+1];
  logic signed [WD-1:0] vy [N+1];
  logic signed [WD-1:0] vz [N+1];

  assign vx[0] = {2'b00, qb_root[F+1]};
  assign vy[0] = {2'b00, qa_root[F+1]};
  assign vz[0] = '0;

  for (genvar k = 0; k < N; k++) begin : g_vec
    hdu_vec_cell #(.FRACTION_BITS(F), .I(k), .WD(WD)) u_cell (
      .clk   (clk),
      .en    (en),
      .x_in  (vx[k]),
      .y_in  (vy[k]),
      .z_in  (vz[k]),
      .x_out (vx[k+1]),
      .y_out (vy[k+1]),
      .z_out (vz[k+1])
    );
  end

  // distance and saturation
  logic signed [32:0] dist_p;
  logic [30:0]        fin_d_r, fin_d_nxt;

  hdu_mul #(.WA(WD), .WB(32), .WO(33), .SH(F)) u_mul_dist (
    .clk (clk), .en (en), .a (vz[N]), .b (hdu_pkg::DIAMETER_CM), .p (dist_p)
  );

  always_comb begin
    if (dist_p[32]) begin
      fin_d_nxt = '0;
    end else if (dist_p > hdu_pkg::MAX_DIST) begin
      fin_d_nxt = 31'(hdu_pkg::MAX_DIST);
    end else begin
      fin_d_nxt = dist_p[30:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      fin_d_r <= fin_d_nxt;
    end
  end

  // valid tracking, output register and skid buffer
  logic        out_v_r, take;
  logic [30:0] out_d_r;
  logic        skid_v_r;
  logic [30:0] skid_d_r;

  assign en      = !skid_v_r;
  assign take    = out_v_r && !out_stall;
  assign vld_nxt = {vld_r[LAT-2:0], in_valid};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      if (en) begin
        vld_r <= vld_nxt;
      end
      if (skid_v_r) begin
        if (take) begin
          skid_v_r <= 1'b0;
        end
      end else if (!out_v_r || take) begin
        out_v_r <= vld_r[LAT-1];
      end else if (vld_r[LAT-1]) begin
        skid_v_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (skid_v_r) begin
      if (take) begin
        out_d_r <= skid_d_r;
      end
    end else if (!out_v_r || take) begin
      out_d_r <= fin_d_r;
    end else begin
      skid_d_r <= fin_d_r;
    end
  end

  assign in_stall        = skid_v_r;
  assign out_valid       = out_v_r;
  assign out_distance_cm = out_d_r;

endmodule

// File: rtl/core/hdu_mul.sv
// two-stage sign-magnitude multiplier from four half-width partial products
module hdu_mul #(
  parameter int WA = 32,
  parameter int WB = 32,
  parameter int WO = 32,
  parameter int SH = 0
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic signed [WA-1:0] a,
  input  logic signed [WB-1:0] b,
  output logic signed [WO-1:0] p
);

  localparam int HA = (WA + 1) / 2;
  localparam int HB = (WB + 1) / 2;
  localparam int WP = WA + WB;
  localparam int W00 = HA + HB;
  localparam int W01 = HA + WB - HB;
  localparam int W10 = WA - HA + HB;
  localparam int W11 = WP - HA - HB;

  logic [WA-1:0]        a_mag;
  logic [WB-1:0]        b_mag;
  logic [W00-1:0]       pp00_r, pp00_nxt;
  logic [W01-1:0]       pp01_r, pp01_nxt;
  logic [W10-1:0]       pp10_r, pp10_nxt;
  logic [W11-1:0]       pp11_r, pp11_nxt;
  logic                 neg_r, neg_nxt;
  logic [WP-1:0]        sum;
  logic [WO-1:0]        mag;
  logic signed [WO-1:0] p_r, p_nxt;

  always_comb begin
    a_mag    = a[WA-1] ? -a : a;
    b_mag    = b[WB-1] ? -b : b;
    neg_nxt  = a[WA-1] ^ b[WB-1];
    pp00_nxt = W00'(a_mag[HA-1:0]) * W00'(b_mag[HB-1:0]);
    pp01_nxt = W01'(a_mag[HA-1:0]) * W01'(b_mag[WB-1:HB]);
    pp10_nxt = W10'(a_mag[WA-1:HA]) * W10'(b_mag[HB-1:0]);
    pp11_nxt = W11'(a_mag[WA-1:HA]) * W11'(b_mag[WB-1:HB]);
  end

  always_comb begin
    sum   = WP'(pp00_r) + (WP'(pp01_r) << HB) + (WP'(pp10_r) << HA)
          + (WP'(pp11_r) << (HA + HB));
    mag   = WO'(sum >> SH);
    p_nxt = neg_r ? -signed'(mag) : signed'(mag);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pp00_r <= pp00_nxt;
      pp01_r <= pp01_nxt;
      pp10_r <= pp10_nxt;
      pp11_r <= pp11_nxt;
      neg_r  <= neg_nxt;
      p_r    <= p_nxt;
    end
  end

  assign p = p_r;

endmodule

// File: rtl/core/hdu_rot_cell.sv
// one rotation-mode cordic iteration with its output register
module hdu_rot_cell #(
  parameter int FRACTION_BITS = 32,
  parameter int I = 0,
  parameter int WD = 35
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic signed [WD-1:0] x_in,
  input  logic signed [WD-1:0] y_in,
  input  logic signed [WD-1:0] z_in,
  output logic signed [WD-1:0] x_out,
  output logic signed [WD-1:0] y_out,
  output logic signed [WD-1:0] z_out
);

  localparam logic signed [WD-1:0] ATAN = WD'(hdu_pkg::atan_frac(I, FRACTION_BITS));

  logic signed [WD-1:0] dx, dy;
  logic signed [WD-1:0] x_r, x_nxt;
  logic signed [WD-1:0] y_r, y_nxt;
  logic signed [WD-1:0] z_r, z_nxt;

  always_comb begin
    dx = y_in >>> I;
    dy = x_in >>> I;
    if (!z_in[WD-1]) begin
      x_nxt = x_in - dx;
      y_nxt = y_in + dy;
      z_nxt = z_in - ATAN;
    end else begin
      x_nxt = x_in + dx;
      y_nxt = y_in - dy;
      z_nxt = z_in + ATAN;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r <= x_nxt;
      y_r <= y_nxt;
      z_r <= z_nxt;
    end
  end

  assign x_out = x_r;
  assign y_out = y_r;
  assign z_out = z_r;

endmodule

// File: rtl/core/hdu_sqrt_cell.sv
// one bit of a restoring square root with its output register
module hdu_sqrt_cell #(
  parameter int FRACTION_BITS = 32,
  parameter int B = 0
) (
  input  logic                         clk,
  input  logic                         en,
  input  logic [2*FRACTION_BITS+1:0]   rem_in,
  input  logic [FRACTION_BITS:0]       root_in,
  output logic [2*FRACTION_BITS+1:0]   rem_out,
  output logic [FRACTION_BITS:0]       root_out
);

  localparam int WR = 2 * FRACTION_BITS + 2;
  localparam int WQ = FRACTION_BITS + 1;

  logic [WR-1:0] term;
  logic          fits;
  logic [WR-1:0] rem_r, rem_nxt;
  logic [WQ-1:0] root_r, root_nxt;

  always_comb begin
    term     = (WR'(root_in) << (B + 1)) | (WR'(1) << (2 * B));
    fits     = rem_in >= term;
    rem_nxt  = fits ? rem_in - term : rem_in;
    root_nxt = fits ? (root_in | (WQ'(1) << B)) : root_in;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r  <= rem_nxt;
      root_r <= root_nxt;
    end
  end

  assign rem_out  = rem_r;
  assign root_out = root_r;

endmodule

// File: rtl/core/hdu_vec_cell.sv
// one vectoring-mode cordic iteration with its output register
module hdu_vec_cell #(
  parameter int FRACTION_BITS = 32,
  parameter int I = 0,
  parameter int WD = 35
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic signed [WD-1:0] x_in,
  input  logic signed [WD-1:0] y_in,
  input  logic signed [WD-1:0] z_in,
  output logic signed [WD-1:0] x_out,
  output logic signed [WD-1:0] y_out,
  output logic signed [WD-1:0] z_out
);

  localparam logic signed [WD-1:0] ATAN = WD'(hdu_pkg::atan_frac(I, FRACTION_BITS));

  logic signed [WD-1:0] dx, dy;
  logic signed [WD-1:0] x_r, x_nxt;
  logic signed [WD-1:0] y_r, y_nxt;
  logic signed [WD-1:0] z_r, z_nxt;

  always_comb begin
    dx = y_in >>> I;
    dy = x_in >>> I;
    if (!y_in[WD-1]) begin
      x_nxt = x_in + dx;
      y_nxt = y_in - dy;
      z_nxt = z_in + ATAN;
    end else begin
      x_nxt = x_in - dx;
      y_nxt = y_in + dy;
      z_nxt = z_in - ATAN;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r <= x_nxt;
      y_r <= y_nxt;
      z_r <= z_nxt;
    end
  end

  assign x_out = x_r;
  assign y_out = y_r;
  assign z_out = z_r;

endmodule
